@@ hdl/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants of the first-fit block allocator
// Request and response beats, sequencer states, status codes and the
// fixed row geometry of the occupancy map.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

    // occupancy map is held as rows of 64 blocks
    localparam int ROW_BITS = 64;
    localparam int OFF_W    = 6;

    // ceil(bytes / block size) fits 25 bits for any block size
    localparam int NEED_W     = 25;

    typedef enum logic
    {
        OP_ALLOC,
        OP_FREE
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_DONE,
        STATUS_INVALID,
        STATUS_NOROOM
    } status_t;

    typedef struct packed
    {
        op_t         op;
        logic [23:0] size_bytes;
        logic [11:0] position;
    } req_t;

    typedef struct packed
    {
        status_t     status;
        logic [11:0] start_block;
    } rsp_t;

    // result of the row search unit
    typedef struct packed
    {
        logic             found;
        logic [OFF_W-1:0] idx;
    } seek_t;

    typedef enum logic [3:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_EVAL,
        ST_FETCH,
        ST_SCAN,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_FCHK_RD,
        ST_FCHK,
        ST_FCLR_RD,
        ST_FCLR_WR,
        ST_RESP
    } state_t;

endpackage : ffa_pkg

`default_nettype wire

@@ hdl/bitmap_first_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator: first-fit run allocator over a block bitmap
// Sequencer, row scan and read-modify-write of the occupancy map.
// ----------------------------------------------------------------------------
// After reset the map is cleared one row of 64 blocks per cycle, so no request
// is taken until the whole map is clear. One request is worked at a time.
// Every request that passes the early checks first goes through the
// block-count unit, a multiply by the reciprocal of the block size. An
// allocate then walks the map with the row search unit, stepping over each
// free or used stretch and crossing each row boundary in turn, then reads and
// writes back each row that the new run covers. A free first reads and checks
// each row that its run spans, then, if all of it is in use, reads and clears
// each of them. The response waits in an output register, so the next request
// may be taken while it is still pending.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_first_fit_allocator
    import ffa_pkg::*;
#(
    parameter int BLOCKS      = 4096,
    parameter int BLOCK_BYTES = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire req_t req,
    input  wire logic req_valid,
    output logic      req_stall,
    output rsp_t      rsp,
    output logic      rsp_valid,
    input  wire logic rsp_stall
);

    localparam int ROWS      = (BLOCKS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int POS_W     = ROW_W + OFF_W;
    localparam int EXT_W     = POS_W + 1;
    localparam int CMP_W     = (EXT_W > NEED_W) ? EXT_W : NEED_W;
    localparam int LAST_BITS = BLOCKS - (ROWS - 1) * ROW_BITS;

    localparam logic [ROW_BITS-1:0] ROW_ONES  = '1;
    localparam logic [ROW_BITS-1:0] LAST_MASK = ROW_ONES >> (ROW_BITS - LAST_BITS);

    state_t              state_reg;
    state_t              state_next;
    op_t                 op_reg;
    op_t                 op_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [NEED_W-1:0]   need_reg;
    logic [NEED_W-1:0]   need_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [OFF_W-1:0]    off_reg;
    logic [OFF_W-1:0]    off_next;
    logic [EXT_W-1:0]    run_start_reg;
    logic [EXT_W-1:0]    run_start_next;
    logic [POS_W-1:0]    first_reg;
    logic [POS_W-1:0]    first_next;
    logic [POS_W-1:0]    last_reg;
    logic [POS_W-1:0]    last_next;
    status_t             status_reg;
    status_t             status_next;
    logic [11:0]         start_reg;
    logic [11:0]         start_next;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;

    logic                ram_we;
    logic [ROW_BITS-1:0] ram_wdata;
    logic                ram_re;
    logic [ROW_W-1:0]    ram_raddr;
    logic [ROW_BITS-1:0] ram_rdata;

    logic                div_start;
    logic                div_done;
    logic [NEED_W-1:0]   div_quotient;
    logic [NEED_W-1:0]   div_dividend;

    logic                req_take;
    logic                req_bad;
    logic                rsp_load;
    logic                row_last;
    logic [EXT_W-1:0]    row_base;
    logic [ROW_BITS-1:0] row_eff;
    logic                cur_used;
    seek_t               seek_res;
    logic [OFF_W:0]      seg_len;
    logic [EXT_W-1:0]    seg_end;
    logic [EXT_W-1:0]    run_len;
    logic                hit;
    logic                seg_found;
    logic                scan_adv;
    logic [CMP_W-1:0]    first_ext;
    logic [CMP_W-1:0]    alloc_last;
    logic [CMP_W-1:0]    free_last;
    logic [CMP_W-1:0]    room_left;
    logic [ROW_W-1:0]    row_first;
    logic [ROW_W-1:0]    row_end;
    logic                row_at_end;
    logic [OFF_W:0]      mask_lo;
    logic [OFF_W:0]      mask_hi;
    logic [ROW_BITS-1:0] run_mask;
    logic                chk_ok;

    // ---------------- shared units ----------------

    ffa_blkdiv #(
        .DIVISOR (BLOCK_BYTES)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quotient)
    );

    ffa_map_ram #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (row_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ffa_seek u_seek (
        .row  (row_eff),
        .off  (off_reg),
        .want (~cur_used),
        .res  (seek_res)
    );

    // ---------------- common datapath terms ----------------

    // request checks that need no block count
    assign req_take = (state_reg == ST_IDLE) && req_valid;
    assign req_bad  = (req.size_bytes == '0) ||
                      ((req.op == OP_FREE) && (CMP_W'(req.position) >= CMP_W'(BLOCKS)));
    assign div_dividend = NEED_W'(req.size_bytes) + NEED_W'(BLOCK_BYTES - 1);

    // scan: blocks past the map end read as used
    assign row_last = (row_reg == ROW_W'(ROWS - 1));
    assign row_base = EXT_W'({row_reg, {OFF_W{1'b0}}});
    assign row_eff  = ram_rdata | ~(row_last ? LAST_MASK : ROW_ONES);
    assign cur_used = row_eff[off_reg];

    // length of the free stretch so far, ending at the next used block
    assign seg_len   = seek_res.found ? {1'b0, seek_res.idx} : (OFF_W + 1)'(ROW_BITS);
    assign seg_end   = row_base + EXT_W'(seg_len);
    assign run_len   = seg_end - run_start_reg;
    assign hit       = !cur_used && (CMP_W'(run_len) >= CMP_W'(need_reg));
    assign seg_found = seek_res.found;
    assign scan_adv  = !hit && !seg_found && !row_last;

    // run bounds
    assign first_ext  = CMP_W'(run_start_reg);
    assign alloc_last = first_ext + CMP_W'(need_reg) - 1'b1;
    assign free_last  = CMP_W'(pos_reg) + CMP_W'(need_reg) - 1'b1;
    assign room_left  = CMP_W'(BLOCKS) - CMP_W'(pos_reg);

    // bits of the current row that the run covers
    assign row_first  = first_reg[POS_W-1:OFF_W];
    assign row_end    = last_reg[POS_W-1:OFF_W];
    assign row_at_end = (row_reg == row_end);
    assign mask_lo    = (row_reg == row_first) ? {1'b0, first_reg[OFF_W-1:0]} : '0;
    assign mask_hi    = row_at_end ? ({1'b0, last_reg[OFF_W-1:0]} + 1'b1)
                                   : (OFF_W + 1)'(ROW_BITS);
    assign run_mask   = (ROW_ONES << mask_lo) & ~(ROW_ONES << mask_hi);
    assign chk_ok     = ((ram_rdata & run_mask) == run_mask);

    assign rsp_load = (state_reg == ST_RESP) && (!rsp_valid_reg || !rsp_stall);

    // ---------------- sequencer: next state ----------------

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (row_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = req_bad ? ST_RESP : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    state_next = (CMP_W'(need_reg) > CMP_W'(BLOCKS)) ? ST_RESP : ST_FETCH;
                end
                else
                begin
                    state_next = (CMP_W'(need_reg) > room_left) ? ST_RESP : ST_FCHK_RD;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = ST_MARK_RD;
                end
                else if (!seg_found && row_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_MARK_RD:
            begin
                state_next = ST_MARK_WR;
            end
            ST_MARK_WR:
            begin
                state_next = row_at_end ? ST_RESP : ST_MARK_RD;
            end
            ST_FCHK_RD:
            begin
                state_next = ST_FCHK;
            end
            ST_FCHK:
            begin
                if (!chk_ok)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = row_at_end ? ST_FCLR_RD : ST_FCHK_RD;
                end
            end
            ST_FCLR_RD:
            begin
                state_next = ST_FCLR_WR;
            end
            ST_FCLR_WR:
            begin
                state_next = row_at_end ? ST_RESP : ST_FCLR_RD;
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- sequencer: outputs ----------------

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = row_reg;
        div_start = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_IDLE:
            begin
                div_start = req_valid && !req_bad;
            end
            ST_FETCH, ST_MARK_RD, ST_FCHK_RD, ST_FCLR_RD:
            begin
                ram_re = 1'b1;
            end
            ST_SCAN:
            begin
                ram_re    = scan_adv;
                ram_raddr = row_reg + 1'b1;
            end
            ST_MARK_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | run_mask;
            end
            ST_FCLR_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~run_mask;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);

    // ---------------- datapath next values ----------------

    always_comb
    begin
        op_next        = op_reg;
        pos_next       = pos_reg;
        need_next      = need_reg;
        row_next       = row_reg;
        off_next       = off_reg;
        run_start_next = run_start_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        start_next     = start_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                row_next = row_reg + 1'b1;
            end
            ST_IDLE:
            begin
                op_next     = req.op;
                pos_next    = POS_W'(req.position);
                status_next = STATUS_INVALID;
                start_next  = '0;
            end
            ST_DIV:
            begin
                need_next = div_quotient;
            end
            ST_EVAL:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    status_next    = STATUS_NOROOM;
                    row_next       = '0;
                    off_next       = '0;
                    run_start_next = '0;
                end
                else
                begin
                    first_next = pos_reg;
                    last_next  = free_last[POS_W-1:0];
                    row_next   = pos_reg[POS_W-1:OFF_W];
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    status_next = STATUS_DONE;
                    start_next  = first_ext[11:0];
                    first_next  = run_start_reg[POS_W-1:0];
                    last_next   = alloc_last[POS_W-1:0];
                    row_next    = run_start_reg[POS_W-1:OFF_W];
                end
                else if (seg_found)
                begin
                    off_next = seek_res.idx;
                    if (cur_used)
                    begin
                        run_start_next = EXT_W'({row_reg, seek_res.idx});
                    end
                end
                else if (!row_last)
                begin
                    row_next = row_reg + 1'b1;
                    off_next = '0;
                    if (cur_used)
                    begin
                        run_start_next = row_base + EXT_W'(ROW_BITS);
                    end
                end
            end
            ST_MARK_WR:
            begin
                row_next = row_reg + 1'b1;
            end
            ST_FCHK:
            begin
                row_next = row_at_end ? row_first : row_reg + 1'b1;
            end
            ST_FCLR_WR:
            begin
                row_next = row_reg + 1'b1;
                if (row_at_end)
                begin
                    status_next = STATUS_DONE;
                end
            end
            default:
            begin
                row_next = row_reg;
            end
        endcase
    end

    // ---------------- registers ----------------

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            row_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // working registers of the current request
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        need_reg      <= need_next;
        off_reg       <= off_next;
        run_start_reg <= run_start_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        status_reg    <= status_next;
        start_reg     <= start_next;
        if (rsp_load)
        begin
            rsp_reg.status      <= status_reg;
            rsp_reg.start_block <= start_reg;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // ---------------- assertions ----------------

    // an accepted beat always starts work
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> (state_reg != ST_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // writes never reach beyond the last row
    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (row_reg <= ROW_W'(ROWS - 1)))
        else $error("map write beyond last row");

    // a found run lies wholly inside the map
    a_hit_inside: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && hit) |->
            ((first_ext + CMP_W'(need_reg)) <= CMP_W'(BLOCKS)))
        else $error("allocated run runs past the map end");

    // every row that is marked or cleared has run bits in it
    a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MARK_WR) || (state_reg == ST_FCLR_WR)) |-> (run_mask != '0))
        else $error("empty run mask on map update");

    // a response is only loaded when the output register is free
    a_rsp_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |=> $stable(rsp_reg))
        else $error("pending response overwritten");

endmodule : bitmap_first_fit_allocator

`default_nettype wire

@@ hdl/ffa_blkdiv.sv @@
// ----------------------------------------------------------------------------
// ffa_blkdiv: block count by the fixed block size
// Reciprocal multiplication by a constant; operand, then product, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_blkdiv
    import ffa_pkg::*;
#(
    parameter int DIVISOR = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [NEED_W-1:0] dividend,
    output logic                   done,
    output logic      [NEED_W-1:0] quotient
);

    // floor(n / d) = (n * ceil(2^(NEED_W+L) / d)) >> (NEED_W+L), L = ceil(log2 d);
    // exact for every n below 2^NEED_W, and the multiplier fits NEED_W+1 bits
    localparam int               LOG_D      = $clog2(DIVISOR);
    localparam int               SHIFT      = NEED_W + LOG_D;
    localparam int               MUL_W      = NEED_W + 1;
    localparam int               PROD_W     = NEED_W + MUL_W;
    localparam logic [63:0]      RECIP_WIDE = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1)
                                              / 64'(DIVISOR);
    localparam logic [MUL_W-1:0] RECIP      = RECIP_WIDE[MUL_W-1:0];

    logic [NEED_W-1:0] dvd_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic              busy_reg;
    logic              done_reg;

    // multiply by the constant reciprocal
    assign prod_next = PROD_W'(dvd_reg) * PROD_W'(RECIP);

    // control: operand loaded, then product loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
        end
        if (busy_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign done     = done_reg;
    assign quotient = NEED_W'(prod_reg >> SHIFT);

endmodule : ffa_blkdiv

`default_nettype wire

@@ hdl/ffa_map_ram.sv @@
// ----------------------------------------------------------------------------
// ffa_map_ram: occupancy map storage
// One row of 64 blocks per entry, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_map_ram
    import ffa_pkg::*;
#(
    parameter int ROWS  = 64,
    parameter int ROW_W = 6
)
(
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [ROW_W-1:0]    waddr,
    input  wire logic [ROW_BITS-1:0] wdata,
    input  wire logic                re,
    input  wire logic [ROW_W-1:0]    raddr,
    output logic      [ROW_BITS-1:0] rdata
);

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : ffa_map_ram

`default_nettype wire

@@ hdl/ffa_seek.sv @@
// ----------------------------------------------------------------------------
// ffa_seek: row search unit
// Finds the lowest bit at or above an offset in a row that has a given value.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_seek
    import ffa_pkg::*;
(
    input  wire logic [ROW_BITS-1:0] row,
    input  wire logic [OFF_W-1:0]    off,
    input  wire logic                want,
    output seek_t                    res
);

    localparam logic [ROW_BITS-1:0] ROW_ONES = '1;

    logic [ROW_BITS-1:0] cand;

    // candidates at or above the offset, then lowest set bit wins
    always_comb
    begin
        cand      = (want ? row : ~row) & (ROW_ONES << off);
        res.found = 1'b0;
        res.idx   = '0;
        for (int j = ROW_BITS - 1; j >= 0; j--)
        begin
            if (cand[j])
            begin
                res.found = 1'b1;
                res.idx   = OFF_W'(j);
            end
        end
    end

endmodule : ffa_seek

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for bitmap_first_fit_allocator
// Drives allocate and release requests and predicts each response from a
// private copy of the occupancy map. Responses are checked in order, field by
// field. A directed opening covers the corner cases, then mostly well-formed
// random traffic with some noise, random idling on both sides and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import ffa_pkg::*;

    localparam int MAP_BLOCKS   = 4096;
    localparam int BLK_BYTES    = 4;
    localparam int RANDOM_ITEMS = 1380;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    // worst fragmented allocate walks ~4k stretches; keep well clear of it
    localparam int STUCK_LIMIT  = 20000;

    // ------------------------------------------------------------------------
    // Occupancy predictor and store of expected responses
    // ------------------------------------------------------------------------
    class alloc_scoreboard;
        bit   used_map [MAP_BLOCKS];
        int   blocks_used;
        rsp_t expected_q [$];
        int   n_errors;
        int   n_requests;
        int   n_alloc_ok;
        int   n_free_ok;
        int   n_invalid;
        int   n_noroom;

        // apply one request to the map and return the response it gives
        function rsp_t predict(req_t r);
            rsp_t   res;
            longint need;
            longint run;
            int     first;
            bit     all_used;
            res.status      = STATUS_DONE;
            res.start_block = '0;
            need = (longint'(r.size_bytes) + BLK_BYTES - 1) / BLK_BYTES;
            if (r.size_bytes == 0)
            begin
                res.status = STATUS_INVALID;
            end
            else if (r.op == OP_ALLOC)
            begin
                // first fit: lowest-index free run of the needed length
                res.status = STATUS_NOROOM;
                run = 0;
                if (need <= MAP_BLOCKS)
                begin
                    for (int i = 0; i < MAP_BLOCKS; i++)
                    begin
                        if (used_map[i])
                        begin
                            run = 0;
                        end
                        else
                        begin
                            run++;
                            if (run == need)
                            begin
                                first = i + 1 - int'(need);
                                for (int k = first; k <= i; k++)
                                    used_map[k] = 1'b1;
                                blocks_used += int'(need);
                                res.status      = STATUS_DONE;
                                res.start_block = 12'(first);
                                break;
                            end
                        end
                    end
                end
            end
            else if (need > MAP_BLOCKS - int'(r.position))
            begin
                res.status = STATUS_INVALID;
            end
            else
            begin
                // release only if the whole run is in use
                all_used = 1'b1;
                for (int k = int'(r.position); k < int'(r.position) + int'(need); k++)
                    all_used &= used_map[k];
                if (all_used)
                begin
                    for (int k = int'(r.position); k < int'(r.position) + int'(need); k++)
                        used_map[k] = 1'b0;
                    blocks_used -= int'(need);
                end
                else
                begin
                    res.status = STATUS_INVALID;
                end
            end
            return res;
        endfunction

        function void note_request(req_t r);
            rsp_t res;
            res = predict(r);
            n_requests++;
            case (res.status)
                STATUS_DONE:
                    if (r.op == OP_ALLOC) n_alloc_ok++;
                    else n_free_ok++;
                STATUS_INVALID: n_invalid++;
                default:        n_noroom++;
            endcase
            expected_q.push_back(res);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_q.size() == 0)
            begin
                $error("response beat with nothing outstanding: status %0d start_block %0d",
                       got.status, got.start_block);
                n_errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                n_errors++;
            end
            if (got.start_block !== want.start_block)
            begin
                $error("start_block: expected %0d, got %0d", want.start_block,
                       got.start_block);
                n_errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    req_t req;
    logic req_valid;
    logic req_stall;
    rsp_t rsp;
    logic rsp_valid;
    logic rsp_stall;

    alloc_scoreboard sb;
    bit              quiet;
    bit              hold_request;

    bitmap_first_fit_allocator #(
        .BLOCKS      (MAP_BLOCKS),
        .BLOCK_BYTES (BLK_BYTES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic req_t make_req(op_t op, logic [23:0] size_bytes,
                                      logic [11:0] position);
        req_t r;
        r.op         = op;
        r.size_bytes = size_bytes;
        r.position   = position;
        return r;
    endfunction

    // any byte count that rounds up to n blocks
    function automatic logic [23:0] bytes_for(int n);
        return 24'((n - 1) * BLK_BYTES + $urandom_range(1, BLK_BYTES));
    endfunction

    // ------------------------------------------------------------------------
    // Random request: mostly sensible allocs and releases, some noise
    // ------------------------------------------------------------------------
    function automatic req_t random_request();
        int   sel;
        int   n;
        int   p;
        int   stretch;
        req_t r;
        sel = $urandom_range(0, 99);
        r   = make_req(OP_ALLOC, '0, 12'($urandom));
        if (sel < 18)
        begin
            case ($urandom_range(0, 3))
                0: r = make_req(op_t'($urandom_range(0, 1)), 24'($urandom), 12'($urandom));
                1: r = make_req(OP_FREE, 24'($urandom_range(1, 64)), 12'($urandom));
                2: r = make_req(op_t'($urandom_range(0, 1)), '0, 12'($urandom));
                default:
                    r.size_bytes = 24'($urandom_range(MAP_BLOCKS * BLK_BYTES + 1,
                                                      24'hFF_FFFF));
            endcase
        end
        else if (sb.blocks_used == 0 || (sel < 60 && sb.blocks_used < 3000))
        begin
            sel = $urandom_range(0, 99);
            if (sel < 80)      n = $urandom_range(1, 16);
            else if (sel < 95) n = $urandom_range(17, 256);
            else               n = $urandom_range(257, 2048);
            r.size_bytes = bytes_for(n);
        end
        else
        begin
            // release from some used block, at most to the end of its used stretch
            p = $urandom_range(0, MAP_BLOCKS - 1);
            while (!sb.used_map[p])
                p = (p + 1) % MAP_BLOCKS;
            stretch = 0;
            while (p + stretch < MAP_BLOCKS && sb.used_map[p + stretch])
                stretch++;
            n = ($urandom_range(0, 9) < 7) ? stretch : $urandom_range(1, stretch);
            r = make_req(OP_FREE, bytes_for(n), 12'(p));
        end
        return r;
    endfunction

    // offer one request beat and hold it until taken
    task automatic send_request(input req_t r, input bit may_idle);
        if (may_idle && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(r);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        req_t r;
        req_t directed_q [$];
        bit   tx_idle_on;
        sb           = new();
        quiet        = 1'b0;
        hold_request = 1'b0;
        tx_idle_on   = 1'b1;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // zero sizes, oversize, whole map, run past the end, partial and
        // double release, release over a free hole
        directed_q.push_back(make_req(OP_ALLOC, 24'd0, 12'd0));
        directed_q.push_back(make_req(OP_FREE, 24'd0, 12'd0));
        directed_q.push_back(make_req(OP_ALLOC, 24'hFF_FFFF, 12'hFFF));
        directed_q.push_back(make_req(OP_ALLOC, 24'd16385, 12'd0));
        directed_q.push_back(make_req(OP_ALLOC, 24'd16384, 12'd0));
        directed_q.push_back(make_req(OP_ALLOC, 24'd1, 12'd0));
        directed_q.push_back(make_req(OP_FREE, 24'd8, 12'd4094));
        directed_q.push_back(make_req(OP_ALLOC, 24'd12, 12'd0));
        directed_q.push_back(make_req(OP_ALLOC, 24'd8, 12'd0));
        directed_q.push_back(make_req(OP_FREE, 24'd16384, 12'd0));
        directed_q.push_back(make_req(OP_ALLOC, 24'd1, 12'hFFF));
        directed_q.push_back(make_req(OP_ALLOC, 24'd5, 12'd0));
        directed_q.push_back(make_req(OP_ALLOC, 24'd4, 12'd0));
        directed_q.push_back(make_req(OP_FREE, 24'd4, 12'd4095));
        directed_q.push_back(make_req(OP_FREE, 24'd5, 12'd4095));
        directed_q.push_back(make_req(OP_FREE, 24'hFF_FFFF, 12'd4090));
        directed_q.push_back(make_req(OP_FREE, 24'd8, 12'd1));
        directed_q.push_back(make_req(OP_FREE, 24'd4, 12'd1));
        directed_q.push_back(make_req(OP_FREE, 24'd16, 12'd0));
        directed_q.push_back(make_req(OP_ALLOC, 24'd9, 12'd0));
        directed_q.push_back(make_req(OP_FREE, 24'd4, 12'd0));
        directed_q.push_back(make_req(OP_FREE, 24'd16, 12'd3));
        directed_q.push_back(make_req(OP_FREE, 24'd1, 12'd4090));
        foreach (directed_q[i])
            send_request(directed_q[i], 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
                tx_idle_on = ($urandom_range(0, 2) != 0);
            if (n == HOLD_AT)
                hold_request = 1'b1;
            if (n == RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            r = random_request();
            send_request(r, tx_idle_on && !quiet);
        end
        req_valid <= 1'b0;

        // drain, then leave room for a late stray beat
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d requests, %0d allocations and %0d releases succeeded",
                 sb.n_requests, sb.n_alloc_ok, sb.n_free_ok);
        $display("tb: %0d rejected as invalid, %0d with no room, %0d mismatches",
                 sb.n_invalid, sb.n_noroom, sb.n_errors);
        if (sb.n_errors == 0 && sb.expected_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Response stall: short random bursts, one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin
        int cyc;
        bit rx_idle_on;
        rsp_stall  = 1'b0;
        cyc        = 0;
        rx_idle_on = 1'b1;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 100 == 0)
                rx_idle_on = ($urandom_range(0, 2) != 0);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else if (rx_idle_on && !quiet && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor and watchdog on beats in either direction
    // ------------------------------------------------------------------------
    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && !rsp_stall)
                sb.check_response(rsp);
            if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("tb: no beat for %0d cycles", STUCK_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule : tb

`default_nettype wire
